// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/htfd_pkg.sv =====
// Types, constants and the CRC-8 byte update for the frame decoder.
// No dependencies.
package htfd_pkg;

   localparam logic [7:0]  CRC_POLY     = 8'h31;
   localparam logic [7:0]  CRC_INIT     = 8'hFF;
   localparam logic [14:0] TEMP_SCALE   = 15'd17500;
   localparam logic [15:0] TEMP_BIAS    = 16'd4500;
   localparam logic [13:0] HUM_SCALE    = 14'd10000;
   localparam logic [10:0] OFFSET_RESET = 11'd400;

   // Frame tracker view of the byte held in the input stage
   typedef struct packed {
      logic        last;       // byte completes a frame
      logic        fail;       // either CRC mismatched
      logic [15:0] temp_word;
      logic [15:0] hum_word;
   } frame_info_type;

   // CRC-8, MSB first, no reflection, no final xor
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== hdl/htfd_frame.sv =====
// Byte position tracking, running CRC and word capture for the frame decoder.
// Depends on htfd_pkg.
module htfd_frame import htfd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           take,        // item in the input stage is consumed
   input  logic [7:0]     rx_byte,
   input  logic           frame_start,
   output frame_info_type info
);

   typedef enum logic [2:0] {
      POS_T_MSB = 3'd0,
      POS_T_LSB = 3'd1,
      POS_T_CRC = 3'd2,
      POS_H_MSB = 3'd3,
      POS_H_LSB = 3'd4,
      POS_H_CRC = 3'd5
   } pos_type;

   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic        failed_ff, failed_in;
   logic [15:0] temp_word_ff, temp_word_in;
   logic [7:0]  hum_hi_ff, hum_hi_in;
   logic [7:0]  hum_lo_ff, hum_lo_in;

   pos_type    pos_eff;
   logic [7:0] crc_base;
   logic       fail_base;
   logic [7:0] crc_next;

   // Frame start restarts the count; unused positions count as the first byte
   always_comb begin
      if (frame_start) begin
         pos_eff = POS_T_MSB;
      end else begin
         unique case (pos_ff)
            POS_T_MSB: pos_eff = POS_T_MSB;
            POS_T_LSB: pos_eff = POS_T_LSB;
            POS_T_CRC: pos_eff = POS_T_CRC;
            POS_H_MSB: pos_eff = POS_H_MSB;
            POS_H_LSB: pos_eff = POS_H_LSB;
            POS_H_CRC: pos_eff = POS_H_CRC;
            default:   pos_eff = POS_T_MSB;
         endcase
      end
      crc_base  = frame_start ? CRC_INIT : crc_ff;
      fail_base = frame_start ? 1'b0 : failed_ff;
      crc_next  = crc8_byte(crc_base, rx_byte);
   end

   // Per-position state update
   always_comb begin
      pos_in       = pos_eff + 3'd1;
      crc_in       = crc_base;
      failed_in    = fail_base;
      temp_word_in = temp_word_ff;
      hum_hi_in    = hum_hi_ff;
      hum_lo_in    = hum_lo_ff;
      unique case (pos_eff)
         POS_T_MSB: begin
            crc_in       = crc_next;
            temp_word_in = {rx_byte, temp_word_ff[7:0]};
         end
         POS_T_LSB: begin
            crc_in       = crc_next;
            temp_word_in = {temp_word_ff[15:8], rx_byte};
         end
         POS_T_CRC: begin
            failed_in = fail_base | (crc_base != rx_byte);
            crc_in    = CRC_INIT;
         end
         POS_H_MSB: begin
            crc_in    = crc_next;
            hum_hi_in = rx_byte;
         end
         POS_H_LSB: begin
            crc_in    = crc_next;
            hum_lo_in = rx_byte;
         end
         POS_H_CRC: begin
            pos_in    = POS_T_MSB;
            crc_in    = CRC_INIT;
            failed_in = 1'b0;
         end
         default: begin
            pos_in = POS_T_MSB;
         end
      endcase
   end

   // Frame summary for the conversion stage
   always_comb begin
      info.last      = (pos_eff == POS_H_CRC);
      info.fail      = fail_base | (crc_base != rx_byte);
      info.temp_word = temp_word_ff;
      info.hum_word  = {hum_hi_ff, hum_lo_ff};
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_T_MSB;
         crc_ff    <= CRC_INIT;
         failed_ff <= 1'b0;
      end else if (take) begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         failed_ff <= failed_in;
      end
   end

   // Captured words, cleared on reset as the frame registers
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_word_ff <= '0;
         hum_hi_ff    <= '0;
         hum_lo_ff    <= '0;
      end else if (take) begin
         temp_word_ff <= temp_word_in;
         hum_hi_ff    <= hum_hi_in;
         hum_lo_ff    <= hum_lo_in;
      end
   end

endmodule

// ===== hdl/htfd_convert.sv =====
// Fixed-point conversion of the raw words to centi-degrees and centi-percent.
// Depends on htfd_pkg.
module htfd_convert import htfd_pkg::*; (
   input  frame_info_type     info,
   input  logic [10:0]        offset,
   output logic signed [14:0] temperature_centi,
   output logic [13:0]        humidity_centi,
   output logic               status
);

   logic [30:0]        temp_prod;
   logic [29:0]        hum_prod;
   logic signed [15:0] temp_full;

   // floor(scale * raw / 65536), then bias and self-heating offset
   always_comb begin
      temp_prod = 31'(TEMP_SCALE) * 31'(info.temp_word);
      hum_prod  = 30'(HUM_SCALE) * 30'(info.hum_word);
      temp_full = signed'({1'b0, temp_prod[30:16]}) - signed'(TEMP_BIAS)
                  - signed'({5'd0, offset});
      status    = info.fail;
      if (info.fail) begin
         temperature_centi = '0;
         humidity_centi    = '0;
      end else begin
         temperature_centi = temp_full[14:0];
         humidity_centi    = hum_prod[29:16];
      end
   end

endmodule

// ===== hdl/humidity_temp_frame_decoder.sv =====
// Top level of the temperature/humidity response frame decoder.
// Depends on htfd_pkg, htfd_frame and htfd_convert.
//
// Takes one response byte per item and returns one result after the sixth byte of a frame
// (temperature word, CRC, humidity word, CRC). Each byte is held in the input register;
// the frame tracker and the constant multiplies sit between that register and the
// result register, so one item is accepted in every cycle unless a held result stalls a
// closing byte, and a result is registered as its closing byte leaves the input register.
// Other bytes keep flowing. The self-heating offset is written through the csr port,
// which is always ready; it should change only while no frame is in flight.
module humidity_temp_frame_decoder import htfd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi,
   output logic               rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [10:0]        csr_self_heat_offset
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               in_start_ff;
   logic               out_valid_ff, out_valid_in;
   logic signed [14:0] out_temp_ff, out_temp_in;
   logic [13:0]        out_hum_ff, out_hum_in;
   logic               out_status_ff, out_status_in;
   logic [10:0]        offset_ff;
   logic               out_free, consume, req_take;
   frame_info_type     info;

   htfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .take        (consume),
      .rx_byte     (in_byte_ff),
      .frame_start (in_start_ff),
      .info        (info)
   );

   htfd_convert u_convert (
      .info              (info),
      .offset            (offset_ff),
      .temperature_centi (out_temp_in),
      .humidity_centi    (out_hum_in),
      .status            (out_status_in)
   );

   // Flow control: only a closing byte needs a free result slot
   always_comb begin
      out_free     = !out_valid_ff || !rsp_stall;
      consume      = in_valid_ff && (!info.last || out_free);
      req_stall    = in_valid_ff && !consume;
      req_take     = req_valid && !req_stall;
      in_valid_in  = req_take || (in_valid_ff && !consume);
      out_valid_in = (consume && info.last) || (out_valid_ff && rsp_stall);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         offset_ff    <= OFFSET_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            offset_ff <= csr_self_heat_offset;
         end
      end
   end

   // Input item register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_rx_byte;
         in_start_ff <= req_frame_start;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (consume && info.last) begin
         out_temp_ff   <= out_temp_in;
         out_hum_ff    <= out_hum_in;
         out_status_ff <= out_status_in;
      end
   end

   assign csr_ready             = 1'b1;
   assign rsp_valid             = out_valid_ff;
   assign rsp_temperature_centi = out_temp_ff;
   assign rsp_humidity_centi    = out_hum_ff;
   assign rsp_status            = out_status_ff;

endmodule

// ===== hdl/htfd_checker.sv =====
// Port-level checks for the frame decoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module htfd_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [14:0] rsp_temperature_centi,
   input logic [13:0]        rsp_humidity_centi,
   input logic               rsp_status
);

   logic [29:0] rsp_payload;
   logic        readings_in_range;

   // Result item as one word, and the conversion range of its readings
   assign rsp_payload       = {rsp_temperature_centi, rsp_humidity_centi, rsp_status};
   assign readings_in_range = (rsp_humidity_centi <= 14'd9999)
                              && (rsp_temperature_centi >= -15'sd6547)
                              && (rsp_temperature_centi <= 15'sd12999);

   // A stalled result item holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // CRC failure zeroes both readings
   `ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_valid && rsp_status, rsp_payload[29:1] == '0)

   // Readings stay inside the conversion range
   `ASSERT_IMPLY(a_range, clock, reset, rsp_valid && !rsp_status, readings_in_range)

   // Reset empties the result stage
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind humidity_temp_frame_decoder htfd_checker u_checker (.*);
